// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while in reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant, off while in reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== sv/lonc_pkg.sv =====
`timescale 1ns / 1ps

package lonc_pkg;

  localparam int AFTERGLOW_ENTRIES_DEF = 9;
  localparam int AG_TABLE_LEN = 9;

  localparam logic [16:0] AG_ONE = 17'd65536;

  localparam logic [11:0] AG_THRESH [AG_TABLE_LEN] = '{
    12'd213, 12'd321, 12'd423, 12'd597, 12'd700, 12'd873, 12'd1041, 12'd1179, 12'd1317
  };
  localparam logic [16:0] AG_FACTOR [AG_TABLE_LEN] = '{
    17'd65012, 17'd64881, 17'd64750, 17'd64553, 17'd64487,
    17'd64291, 17'd64160, 17'd64029, 17'd63898
  };

  // register indexes
  localparam logic [1:0] CFG_OCC1_NORM       = 2'd0;
  localparam logic [1:0] CFG_PILEUP_NORM     = 2'd1;
  localparam logic [1:0] CFG_ALPHA_LINEAR    = 2'd2;
  localparam logic [1:0] CFG_ALPHA_QUADRATIC = 2'd3;

  // reset values
  localparam logic [31:0] OCC1_NORM_RST       = 32'd416808960;
  localparam logic [31:0] PILEUP_NORM_RST     = 32'd417464320;
  localparam logic [31:0] ALPHA_LINEAR_RST    = 32'd67645735;
  localparam logic [31:0] ALPHA_QUADRATIC_RST = 32'hFFC3_6114;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DEN_BAD = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  typedef struct packed {
    logic [31:0] raw_lumi;
    logic [11:0] bunch_count;
  } in_t;

  typedef struct packed {
    logic [31:0] norm_factor;
    logic [1:0]  status;
  } out_t;

endpackage

// ===== sv/lonc_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage
module lonc_div import lonc_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 12,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [TW-1:0] out_tag
);

  logic [NW-1:0] v_r;
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [TW-1:0] tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [TW-1:0] tag_p;
    logic [DW:0]   acc;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] num_nxt;

    if (k == 0) begin : g_first
      assign v_p   = in_valid;
      assign rem_p = '0;
      assign num_p = in_num;
      assign den_p = in_den;
      assign tag_p = in_tag;
    end else begin : g_next
      assign v_p   = v_r[k-1];
      assign rem_p = rem_r[k-1];
      assign num_p = num_r[k-1];
      assign den_p = den_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    assign acc     = {rem_p, num_p[NW-1]};
    assign ge      = acc >= {1'b0, den_p};
    assign rem_nxt = ge ? DW'(acc - {1'b0, den_p}) : acc[DW-1:0];
    assign num_nxt = {num_p[NW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_p;
      end
      rem_r[k] <= rem_nxt;
      num_r[k] <= num_nxt;
      den_r[k] <= den_p;
      tag_r[k] <= tag_p;
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = num_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule

// ===== sv/lumi_occupancy_norm_correction_top.sv =====
`timescale 1ns / 1ps

// channel  | ports                          | when a word moves
// ---------+--------------------------------+------------------------------
// input    | start, busy, in_data           | start high and busy low
// result   | out_strobe, out_data           | out_strobe high, no stall
// config   | cfg_we, cfg_index, cfg_wdata   | cfg_we high
//
// one word enters per cycle; busy is never raised
// each result passes through 48 + 63 divider stages plus seven pipeline
// registers; throughput is one word per cycle
// synchronous active-low reset clears the valid pipe and the configuration registers
// the receiver cannot stall, so nothing in the pipe ever waits
module lumi_occupancy_norm_correction_top import lonc_pkg::*; #(
  parameter int AFTERGLOW_ENTRIES = AFTERGLOW_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_strobe,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int AG_USED = (AFTERGLOW_ENTRIES < AG_TABLE_LEN) ? AFTERGLOW_ENTRIES
                                                              : AG_TABLE_LEN;
  localparam int DIV1_W = 48;
  localparam int DIV2_W = 63;
  localparam int LATENCY = 1 + DIV1_W + 5 + DIV2_W + 1;

  // configuration registers
  logic [31:0] occ1_r, pileup_r, alin_r, aquad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ1_r   <= OCC1_NORM_RST;
      pileup_r <= PILEUP_NORM_RST;
      alin_r   <= ALPHA_LINEAR_RST;
      aquad_r  <= ALPHA_QUADRATIC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCC1_NORM:       occ1_r   <= cfg_wdata;
        CFG_PILEUP_NORM:     pileup_r <= cfg_wdata;
        CFG_ALPHA_LINEAR:    alin_r   <= cfg_wdata;
        CFG_ALPHA_QUADRATIC: aquad_r  <= cfg_wdata;
      endcase
    end
  end

  // alpha magnitudes and signs
  logic        n1, n2;
  logic [31:0] m1, m2;
  assign n1 = alin_r[31];
  assign n2 = aquad_r[31];
  assign m1 = n1 ? (32'd0 - alin_r) : alin_r;
  assign m2 = n2 ? (32'd0 - aquad_r) : aquad_r;

  // no backpressure anywhere in the pipe
  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // afterglow lookup: last threshold not above the count wins
  logic [16:0] ag;
  always_comb begin
    ag = AG_ONE;
    for (int i = 0; i < AG_USED; i++) begin
      if (in_data.bunch_count >= AG_THRESH[i]) ag = AG_FACTOR[i];
    end
  end

  // stage 1: pile-up scaling product
  logic        s1_v_r, s1_zero_r;
  logic [63:0] s1_prod_r;
  logic [11:0] s1_cnt_r;
  logic [16:0] s1_ag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
    end
    s1_prod_r <= 64'(pileup_r) * 64'(in_data.raw_lumi);
    s1_cnt_r  <= in_data.bunch_count;
    s1_zero_r <= in_data.bunch_count == 12'd0;
    s1_ag_r   <= ag;
  end

  // per-bunch average
  logic              d1_v;
  logic [DIV1_W-1:0] d1_q;
  logic [17:0]       d1_tag;

  lonc_div #(.NW(DIV1_W), .DW(12), .TW(18)) u_avg_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_num    (s1_prod_r[63:16]),
    .in_den    (s1_cnt_r),
    .in_tag    ({s1_ag_r, s1_zero_r}),
    .out_valid (d1_v),
    .out_quot  (d1_q),
    .out_tag   (d1_tag)
  );

  // stage 2: average saturation, zero count forces zero
  logic        s2_v_r, s2_sat_r;
  logic [31:0] s2_avg_r;
  logic [16:0] s2_ag_r;
  logic        d1_big;
  assign d1_big = |d1_q[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= d1_v;
    end
    s2_avg_r <= d1_tag[0] ? 32'd0 : (d1_big ? 32'hFFFF_FFFF : d1_q[31:0]);
    s2_sat_r <= !d1_tag[0] && d1_big;
    s2_ag_r  <= d1_tag[17:1];
  end

  // stage 3: square and linear term
  logic        s3_v_r, s3_sat_r;
  logic [63:0] s3_sq_r, s3_lin_prod;
  logic [47:0] s3_t1_r;
  logic [16:0] s3_ag_r;
  assign s3_lin_prod = 64'(m1) * 64'(s2_avg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_sq_r  <= 64'(s2_avg_r) * 64'(s2_avg_r);
    s3_t1_r  <= s3_lin_prod[63:16];
    s3_sat_r <= s2_sat_r;
    s3_ag_r  <= s2_ag_r;
  end

  // stage 4: quadratic partial products, numerator product
  logic        s4_v_r, s4_sat_r;
  logic [63:0] s4_phi_r;
  logic [47:0] s4_plo_r, s4_t1_r;
  logic [48:0] s4_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_phi_r <= 64'(m2) * 64'(s3_sq_r[63:32]);
    s4_plo_r <= 48'(m2) * 48'(s3_sq_r[31:16]);
    s4_t1_r  <= s3_t1_r;
    s4_num_r <= 49'(occ1_r) * 49'(s3_ag_r);
    s4_sat_r <= s3_sat_r;
  end

  // stage 5: positive and negative sums, 64-bit wrap
  logic        s5_v_r, s5_sat_r;
  logic [63:0] s5_pos_r, s5_neg_r;
  logic [48:0] s5_num_r;
  logic [63:0] t1, t2;
  assign t1 = {16'd0, s4_t1_r};
  assign t2 = s4_phi_r + {32'd0, s4_plo_r[47:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_pos_r <= 64'h4000_0000 + (n1 ? 64'd0 : t1) + (n2 ? 64'd0 : t2);
    s5_neg_r <= (n1 ? t1 : 64'd0) + (n2 ? t2 : 64'd0);
    s5_num_r <= s4_num_r;
    s5_sat_r <= s4_sat_r;
  end

  // stage 6: denominator and its sign check
  logic        s6_v_r, s6_sat_r, s6_bad_r;
  logic [63:0] s6_den_r;
  logic [62:0] s6_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_bad_r <= s5_pos_r <= s5_neg_r;
    s6_den_r <= s5_pos_r - s5_neg_r;
    s6_num_r <= {s5_num_r, 14'd0};
    s6_sat_r <= s5_sat_r;
  end

  // final quotient
  logic              d2_v;
  logic [DIV2_W-1:0] d2_q;
  logic [1:0]        d2_tag;

  lonc_div #(.NW(DIV2_W), .DW(64), .TW(2)) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s6_v_r),
    .in_num    (s6_num_r),
    .in_den    (s6_den_r),
    .in_tag    ({s6_bad_r, s6_sat_r}),
    .out_valid (d2_v),
    .out_quot  (d2_q),
    .out_tag   (d2_tag)
  );

  // stage 7: output word; bad denominator wins over saturation
  logic out_v_r;
  out_t out_r, out_nxt;
  logic q_big;
  assign q_big = |d2_q[62:32];

  always_comb begin
    priority if (d2_tag[1]) begin
      out_nxt.norm_factor = 32'd0;
      out_nxt.status      = ST_DEN_BAD;
    end else if (q_big) begin
      out_nxt.norm_factor = 32'hFFFF_FFFF;
      out_nxt.status      = ST_SAT;
    end else begin
      out_nxt.norm_factor = d2_q[31:0];
      out_nxt.status      = d2_tag[0] ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= d2_v;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_data   = out_r;

  // checks
  `ASSERT_IMPLIES(a_bad_den_zero, out_strobe && out_data.status == ST_DEN_BAD,
    out_data.norm_factor == 32'd0, "bad denominator word carries a nonzero factor")
  `ASSERT_IMPLIES(a_status_code, out_strobe,
    out_data.status == ST_OK || out_data.status == ST_DEN_BAD || out_data.status == ST_SAT,
    "undefined status code")
  `ASSERT_IMPLIES(a_latency, out_strobe, $past(in_fire, LATENCY),
    "result word without matching input word")

endmodule
